### sv/iir7_pkg.sv
// ----------------------------------------------------------------------------
// iir7_pkg
// Shared constants, coefficient tables and command type of the order-7 IIR.
// ----------------------------------------------------------------------------
package iir7_pkg;

  localparam int unsigned TAPS_DEF        = 8;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned ROM_TAPS        = 8;
  localparam int unsigned COEF_BITS       = 16;
  localparam int unsigned ACC_BITS        = 32;
  localparam int unsigned RND_SHIFT       = 15;
  localparam logic [ACC_BITS-1:0] ROUND_BIAS = 32'h0000_4000;

  localparam logic signed [COEF_BITS-1:0] COEF_B [ROM_TAPS] = '{
    16'sd581, -16'sd3940, 16'sd11573, -16'sd19087,
    16'sd19087, -16'sd11573, 16'sd3940, -16'sd581
  };

  localparam logic signed [COEF_BITS-1:0] COEF_A [ROM_TAPS] = '{
    16'sd0, -16'sd6440, 16'sd15182, -16'sd20279,
    16'sd16526, -16'sd8190, 16'sd2276, -16'sd271
  };

  typedef struct packed {
    logic load;
    logic mul_en;
    logic mul_fb;
    logic finish;
  } iir7_cmd_t;

  function automatic logic signed [COEF_BITS-1:0] coef_b(input int unsigned k);
    logic signed [COEF_BITS-1:0] c;
    c = '0;
    if (k < ROM_TAPS) begin
      c = COEF_B[k[2:0]];
    end
    return c;
  endfunction

  function automatic logic signed [COEF_BITS-1:0] coef_a(input int unsigned k);
    logic signed [COEF_BITS-1:0] c;
    c = '0;
    if (k < ROM_TAPS) begin
      c = COEF_A[k[2:0]];
    end
    return c;
  endfunction

endpackage

### sv/iir7_in_if.sv
// ----------------------------------------------------------------------------
// iir7_in_if
// Valid/ready channel carrying one input sample per item.
// ----------------------------------------------------------------------------
interface iir7_in_if #(
  parameter int unsigned SAMPLE_BITS = iir7_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

### sv/iir7_out_if.sv
// ----------------------------------------------------------------------------
// iir7_out_if
// Valid/ready channel carrying one filtered sample per item.
// ----------------------------------------------------------------------------
interface iir7_out_if #(
  parameter int unsigned SAMPLE_BITS = iir7_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

### sv/iir7_ctrl.sv
// ----------------------------------------------------------------------------
// iir7_ctrl
// Sequencer: one multiply-accumulate step per cycle over all taps, then
// rounding and hand-over of the result to the output register.
// ----------------------------------------------------------------------------
module iir7_ctrl #(
  parameter int unsigned TAPS = iir7_pkg::TAPS_DEF,
  localparam int unsigned TAP_W = $clog2(TAPS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output iir7_pkg::iir7_cmd_t   cmd_o,
  output logic [TAP_W-1:0]      tap_o
);
  import iir7_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e            state_q, state_d;
  logic [TAP_W-1:0]  k_q, k_d;
  logic              fb_q, fb_d;
  logic              out_valid_q, out_valid_d;
  logic              in_acc;
  logic              last_op;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign tap_o       = k_q;
  assign last_op     = fb_q && (k_q == TAP_W'(TAPS - 1));

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = in_acc;
    cmd_o.mul_en = (state_q == ST_MAC);
    cmd_o.mul_fb = fb_q;
    cmd_o.finish = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    fb_d        = fb_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_MAC;
          k_d     = '0;
          fb_d    = 1'b0;
        end
      end
      ST_MAC: begin
        if (last_op) begin
          state_d = ST_DRAIN;
          fb_d    = 1'b0;
          k_d     = '0;
        end else if (fb_q) begin
          fb_d = 1'b0;
          k_d  = k_q + TAP_W'(1);
        end else begin
          fb_d = 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (cmd_o.finish) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      fb_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      fb_q        <= fb_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_MAC) && (k_q == '0) && !fb_q)
    else $error("accepted item did not start at the first tap");

  a_finish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("result written over a waiting item");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.mul_en || cmd_o.finish) |-> !cmd_o.load)
    else $error("new item loaded while work in progress");
`endif

endmodule

### sv/iir7_dp.sv
// ----------------------------------------------------------------------------
// iir7_dp
// Datapath: sample histories, shared multiplier, accumulator, rounding and
// output register.
// ----------------------------------------------------------------------------
module iir7_dp #(
  parameter int unsigned TAPS        = iir7_pkg::TAPS_DEF,
  parameter int unsigned SAMPLE_BITS = iir7_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned TAP_W      = $clog2(TAPS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  iir7_pkg::iir7_cmd_t           cmd_i,
  input  logic [TAP_W-1:0]              tap_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o
);
  import iir7_pkg::*;

  localparam int unsigned PW   = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned PEXT = (PW > ACC_BITS) ? PW : ACC_BITS;

  logic signed [SAMPLE_BITS-1:0] xh_q [TAPS];
  logic signed [SAMPLE_BITS-1:0] yh_q [TAPS];
  logic [TAP_W-1:0]              pos_q;
  logic [ACC_BITS-1:0]           acc_q;
  logic [ACC_BITS-1:0]           prod_q;
  logic                          prod_valid_q;
  logic                          prod_sub_q;
  logic signed [SAMPLE_BITS-1:0] out_q;

  logic [TAP_W-1:0]              idx;
  logic signed [SAMPLE_BITS-1:0] hist_sel;
  logic signed [COEF_BITS-1:0]   coef_sel;
  logic signed [PW-1:0]          prod_full;
  logic signed [PEXT-1:0]        prod_ext;
  logic [ACC_BITS-1:0]           acc_rnd;
  logic [ACC_BITS-1:0]           shifted;
  logic signed [SAMPLE_BITS-1:0] y_new;

  always_comb begin
    if (pos_q >= tap_i) begin
      idx = pos_q - tap_i;
    end else begin
      idx = TAP_W'((TAP_W + 1)'(pos_q) + (TAP_W + 1)'(TAPS) - (TAP_W + 1)'(tap_i));
    end
  end

  assign hist_sel  = cmd_i.mul_fb ? yh_q[idx] : xh_q[idx];
  assign coef_sel  = cmd_i.mul_fb ? coef_a(32'(tap_i)) : coef_b(32'(tap_i));
  assign prod_full = PW'(hist_sel) * PW'(coef_sel);
  assign prod_ext  = PEXT'(prod_full);

  assign acc_rnd = acc_q + ROUND_BIAS;
  assign shifted = ACC_BITS'($signed(acc_rnd) >>> RND_SHIFT);
  assign y_new   = shifted[SAMPLE_BITS-1:0];

  assign sample_out_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        xh_q[i] <= '0;
        yh_q[i] <= '0;
      end
      pos_q        <= '0;
      acc_q        <= '0;
      prod_valid_q <= 1'b0;
      prod_sub_q   <= 1'b0;
    end else begin
      prod_valid_q <= cmd_i.mul_en;
      prod_sub_q   <= cmd_i.mul_fb;
      if (cmd_i.load) begin
        xh_q[pos_q] <= sample_in_i;
        acc_q       <= '0;
      end else if (prod_valid_q) begin
        if (prod_sub_q) begin
          acc_q <= acc_q - prod_q;
        end else begin
          acc_q <= acc_q + prod_q;
        end
      end
      if (cmd_i.finish) begin
        yh_q[pos_q] <= y_new;
        if (pos_q == TAP_W'(TAPS - 1)) begin
          pos_q <= '0;
        end else begin
          pos_q <= pos_q + TAP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_ext[ACC_BITS-1:0];
    end
    if (cmd_i.finish) begin
      out_q <= y_new;
    end
  end

`ifndef SYNTHESIS
  a_load_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !prod_valid_q)
    else $error("product pending when new sample loaded");

  a_finish_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !prod_valid_q && !cmd_i.mul_en)
    else $error("result taken before accumulation completed");
`endif

endmodule

### sv/iir_filter_q15_order7.sv
// ----------------------------------------------------------------------------
// iir_filter_q15_order7
// Direct-form-I IIR filter of order 7 on signed Q15 audio samples.
// ----------------------------------------------------------------------------
// in_i carries one input sample per item, out_o one filtered sample per item;
// both are valid/ready channels and every accepted input gives exactly one
// output. The block takes an item only when idle. One shared multiplier
// works through the feedforward and feedback taps, one product per cycle:
// a multiply-accumulate step for each feedforward and feedback tap, a
// drain step that adds the last product, and a step that rounds and loads
// the output register. Only then does the block return to idle and take
// the next item, so it does not take a new item while one is in progress.
// The result waits in the output register; if the receiver stalls, the next
// item is still taken and computed, and only its hand-over waits until the
// register is free. Reset clears both sample histories, the write position
// and all handshake state; the block is ready in the first cycle after it.
// ----------------------------------------------------------------------------
module iir_filter_q15_order7 #(
  parameter int unsigned TAPS        = iir7_pkg::TAPS_DEF,
  parameter int unsigned SAMPLE_BITS = iir7_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  iir7_in_if.sink     in_i,
  iir7_out_if.source  out_o
);
  import iir7_pkg::*;

  localparam int unsigned TAP_W = $clog2(TAPS);

  iir7_cmd_t                     cmd;
  logic [TAP_W-1:0]              tap;
  logic                          in_ready;
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid;
  assign out_o.sample_out = sample_out;

  iir7_ctrl #(
    .TAPS(TAPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .tap_o       (tap)
  );

  iir7_dp #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .tap_i        (tap),
    .sample_in_i  (in_i.sample_in),
    .sample_out_o (sample_out)
  );

endmodule

### test/iir_filter_q15_order7_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iir_filter_q15_order7_test
// Self-checking bench for the order-7 Q15 direct-form-I IIR filter.
// A clocked driver feeds samples from a queue over the input channel and
// keeps its own copy of both delay lines. Each accepted sample gives one
// predicted output, built from the fixed coefficient tables with a wrapping
// 32-bit sum, rounding and an arithmetic shift. A clocked monitor compares
// every filtered sample with the oldest prediction. Both sides idle at random
// in bursts, and once the receiver stalls long enough to back the block up.
// A directed run of impulses, steps and full-scale alternation comes first,
// then random samples of mixed size.
// ----------------------------------------------------------------------------
module iir_filter_q15_order7_test;
  import iir7_pkg::*;

  localparam int unsigned TAPS         = TAPS_DEF;
  localparam int unsigned SAMPLE_BITS  = SAMPLE_BITS_DEF;
  localparam int unsigned RANDOM_ITEMS = 1726;
  localparam int unsigned TAIL_ITEMS   = 150;
  localparam int unsigned PRESSURE_AT  = 400;
  localparam int unsigned PRESSURE_LEN = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

  logic clk_i = 1'b0;
  logic rst_ni;

  iir7_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  iir7_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_if ();

  iir_filter_q15_order7 #(
    .TAPS       (TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  logic signed [SAMPLE_BITS-1:0] pending_samples [$];
  logic signed [SAMPLE_BITS-1:0] expected_out [$];
  logic signed [SAMPLE_BITS-1:0] x_line [TAPS];
  logic signed [SAMPLE_BITS-1:0] y_line [TAPS];
  logic [2:0]                    line_pos;

  int unsigned samples_total;
  int unsigned samples_taken;
  int unsigned mismatch_count;
  int unsigned send_gap;
  int unsigned hold_left;
  int unsigned pressure_left;
  logic        pressure_done;
  logic        pressure_hold;
  logic        in_tail;

  assign in_tail       = (samples_taken + TAIL_ITEMS >= samples_total);
  assign pressure_hold = (pressure_left > 0);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // one filter step on the local delay lines
  function automatic logic signed [SAMPLE_BITS-1:0] filter_next(
    input logic signed [SAMPLE_BITS-1:0] x
  );
    logic [ACC_BITS-1:0]           acc;
    logic [2:0]                    slot;
    logic signed [SAMPLE_BITS-1:0] y;
    acc = '0;
    x_line[line_pos] = x;
    for (int k = 0; k < TAPS; k++) begin
      slot = line_pos - 3'(k);
      acc  = acc + 32'(int'(x_line[slot]) * int'(COEF_B[k]));
      acc  = acc - 32'(int'(y_line[slot]) * int'(COEF_A[k]));
    end
    acc = acc + ROUND_BIAS;
    y = acc[RND_SHIFT+SAMPLE_BITS-1:RND_SHIFT];
    y_line[line_pos] = y;
    line_pos = line_pos + 3'd1;
    return y;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.sample_in <= '0;
      samples_taken   <= 0;
      send_gap = 0;
      line_pos = '0;
      for (int k = 0; k < TAPS; k++) begin
        x_line[k] = '0;
        y_line[k] = '0;
      end
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_out.push_back(filter_next(in_if.sample_in));
        samples_taken <= samples_taken + 1;
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (!in_tail && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 8);
          in_if.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_if.valid     <= 1'b1;
          in_if.sample_in <= pending_samples.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver stall so the block fills and holds off its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressure_left <= 0;
      pressure_done <= 1'b0;
    end else if (pressure_left > 0) begin
      pressure_left <= pressure_left - 1;
    end else if (!pressure_done && samples_taken >= PRESSURE_AT) begin
      pressure_done <= 1'b1;
      pressure_left <= PRESSURE_LEN;
    end
  end

  // monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [SAMPLE_BITS-1:0] want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left     = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_out.size() == 0) begin
          $error("sample_out: expected none, got %0d", out_if.sample_out);
          mismatch_count++;
        end else begin
          want = expected_out.pop_front();
          if (out_if.sample_out !== want) begin
            $error("sample_out: expected %0d, got %0d", want, out_if.sample_out);
            mismatch_count++;
          end
        end
      end
      if (pressure_hold) begin
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (!in_tail && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 8);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic signed [SAMPLE_BITS-1:0] directed [$];
    logic signed [SAMPLE_BITS-1:0] s;
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    out_if.ready    = 1'b0;
    rst_ni          = 1'b0;
    mismatch_count  = 0;

    // impulses, unit samples of both signs, full-scale step and alternation for wrap
    directed = '{16'sd0, 16'sd0,
                 SAMPLE_MAX, 16'sd0, 16'sd0, 16'sd0,
                 SAMPLE_MIN, 16'sd0, 16'sd0, 16'sd0,
                 16'sd1, -16'sd1,
                 SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                 SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
                 SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN};
    pending_samples = directed;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: s = SAMPLE_BITS'($urandom());
        5, 6:          s = $signed(16'($urandom_range(0, 512))) - 16'sd256;
        7:             s = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        8:             s = '0;
        default:       s = {$urandom_range(0, 1) ? 2'b01 : 2'b10, 14'($urandom())};
      endcase
      pending_samples.push_back(s);
    end
    samples_total = pending_samples.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (samples_taken != samples_total || expected_out.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("iir_filter_q15_order7: match");
    end else begin
      $display("iir_filter_q15_order7: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("iir_filter_q15_order7: mismatch");
    $finish;
  end

endmodule
